### sv/pss_pkg.sv
// shared types and constants for the per-sensor window statistics block
package pss_pkg;

    localparam int ID_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 26;

    // window sizes above this saturate, zero is taken as one
    localparam int MAX_WINDOW   = 1024;
    localparam int WINDOW_RESET = 8;

    typedef struct packed {
        logic        [ID_W-1:0]     sensor_id;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic        [TIME_W-1:0]   sample_time;
    } pss_reading_t;

    typedef struct packed {
        logic        [ID_W-1:0]     out_sensor_id;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic        [COUNT_W-1:0]  reading_count;
        logic        [TIME_W-1:0]   last_time;
    } pss_stats_t;

    // one word of per-sensor state
    typedef struct packed {
        logic        [COUNT_W-1:0]  fill_count;
        logic signed [SUM_W-1:0]    window_sum;
        logic signed [SAMPLE_W-1:0] window_min;
        logic signed [SAMPLE_W-1:0] window_max;
    } pss_entry_t;

endpackage

### sv/pss_state_mem.sv
// per-sensor state memory with registered read and per-entry valid bits
module pss_state_mem
    import pss_pkg::*;
#(
    parameter int NUM_SENSORS = 16,
    parameter int ADDR_W      = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pss_entry_t        rd_entry,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pss_entry_t        wr_entry
);

    pss_entry_t mem [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] valid_reg;
    pss_entry_t rd_data_reg;
    logic       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // an entry never written reads with a zero fill count
    always_comb
    begin
        rd_entry = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_entry.fill_count = '0;
        end
    end

endmodule

### sv/pss_div.sv
// restoring unsigned divider, one quotient bit per cycle
module pss_div
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [SUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [COUNT_W-1:0] rem_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COUNT_W:0]   trial;
    logic               fits;
    logic [COUNT_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        fits  = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
            cnt_reg  <= CNT_W'(SUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so its low bits suffice
            rem_reg <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/per_sensor_window_stats_top.sv
// top level of the per-sensor windowed min, max and mean block
//
//  channel   dir  handshake                      beat
//  reading   in   reading_valid / reading_ready  pss_reading_t (id, sample, time)
//  stats     out  stats_valid / stats_ready      pss_stats_t (id, min, max, mean, count, time)
//  config    in   cfg_wr_en                      cfg_wr_data, window size
//
//  a reading that does not close a window is accepted, then its sensor's state
//  is read, modified and written back in the lookup state
//  a reading that closes a window then waits in the divide state for the
//  one-bit-per-cycle divider that forms the mean
//  a reading for a sensor id not below NUM_SENSORS is taken and dropped while idle
//  reset clears the fill counts at once through per-entry valid bits, no sweep
//  a waiting result sits in the output register while the next reading is taken;
//  only a second finished mean waits for that register to drain
module per_sensor_window_stats_top
    import pss_pkg::*;
#(
    parameter int NUM_SENSORS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               reading_valid,
    output logic               reading_ready,
    input  pss_reading_t       reading,
    output logic               stats_valid,
    input  logic               stats_ready,
    output pss_stats_t         stats,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIVIDE
    } state_t;

    state_t             state_reg;
    pss_reading_t       beat_reg;
    logic [COUNT_W-1:0] window_size_reg;

    // fields of the closed window, kept while the divider runs
    logic [ID_W-1:0]     pend_id_reg;
    logic [TIME_W-1:0]   pend_time_reg;
    logic [SAMPLE_W-1:0] pend_min_reg;
    logic [SAMPLE_W-1:0] pend_max_reg;
    logic [COUNT_W-1:0]  pend_count_reg;
    logic                pend_neg_reg;

    pss_stats_t stats_reg;
    logic       stats_valid_reg;

    // memory and divider hook-up
    pss_entry_t         rd_entry;
    pss_entry_t         wr_entry;
    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  beat_addr;
    logic [ID_W+ADDR_W-1:0] in_addr_ext;
    logic [ID_W+ADDR_W-1:0] beat_addr_ext;
    logic               id_ok;

    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quotient;
    logic [SUM_W-1:0]   sum_mag;

    logic               in_take;
    logic               out_free;
    logic               stats_load;
    logic [COUNT_W-1:0] eff_window;
    logic [COUNT_W-1:0] new_count;
    logic               window_closed;
    logic signed [SUM_W-1:0] sample_ext;
    logic [SUM_W-1:0]   mean_fixed;

    assign reading_ready = (state_reg == S_IDLE);
    assign in_take       = reading_valid && reading_ready;
    assign out_free      = !stats_valid_reg || stats_ready;

    // finished mean moves into the output register
    assign stats_load    = (state_reg == S_DIVIDE) && div_done && out_free;

    // ids at or above the sensor count are dropped
    assign id_ok         = 32'(reading.sensor_id) < NUM_SENSORS;
    assign in_addr_ext   = {{ADDR_W{1'b0}}, reading.sensor_id};
    assign in_addr       = in_addr_ext[ADDR_W-1:0];
    assign beat_addr_ext = {{ADDR_W{1'b0}}, beat_reg.sensor_id};
    assign beat_addr     = beat_addr_ext[ADDR_W-1:0];
    assign rd_en         = in_take && id_ok;

    // zero counts as one, large values saturate
    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            eff_window = COUNT_W'(1);
        end
        else if (window_size_reg > COUNT_W'(MAX_WINDOW))
        begin
            eff_window = COUNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_window = window_size_reg;
        end
    end

    // read, modify, write back of the addressed sensor
    always_comb
    begin
        sample_ext    = SUM_W'($signed(beat_reg.sample_value));
        new_count     = rd_entry.fill_count + COUNT_W'(1);
        window_closed = (new_count != '0) && (new_count >= eff_window);
        wr_entry      = rd_entry;
        if (rd_entry.fill_count == '0)
        begin
            // first reading of a window loads everything
            wr_entry.window_sum = sample_ext;
            wr_entry.window_min = beat_reg.sample_value;
            wr_entry.window_max = beat_reg.sample_value;
        end
        else
        begin
            wr_entry.window_sum = rd_entry.window_sum + sample_ext;
            if ($signed(beat_reg.sample_value) < $signed(rd_entry.window_min))
            begin
                wr_entry.window_min = beat_reg.sample_value;
            end
            if ($signed(beat_reg.sample_value) > $signed(rd_entry.window_max))
            begin
                wr_entry.window_max = beat_reg.sample_value;
            end
        end
        wr_entry.fill_count = window_closed ? '0 : new_count;
    end

    assign wr_en     = (state_reg == S_LOOKUP);
    assign div_start = wr_en && window_closed;
    assign sum_mag   = wr_entry.window_sum[SUM_W-1] ? SUM_W'(-wr_entry.window_sum)
                                                    : SUM_W'(wr_entry.window_sum);

    // truncation toward zero: divide the magnitude, then restore the sign
    assign mean_fixed = pend_neg_reg ? (~div_quotient + SUM_W'(1)) : div_quotient;

    pss_state_mem #(
        .NUM_SENSORS (NUM_SENSORS),
        .ADDR_W      (ADDR_W)
    ) u_state_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (in_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (beat_addr),
        .wr_entry (wr_entry)
    );

    pss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (new_count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= COUNT_W'(WINDOW_RESET);
            beat_reg        <= '0;
            pend_id_reg     <= '0;
            pend_time_reg   <= '0;
            pend_min_reg    <= '0;
            pend_max_reg    <= '0;
            pend_count_reg  <= '0;
            pend_neg_reg    <= 1'b0;
            stats_reg       <= '0;
            stats_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_size_reg <= cfg_wr_data;
            end

            if (stats_valid_reg && stats_ready && !stats_load)
            begin
                stats_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (rd_en)
                    begin
                        beat_reg  <= reading;
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    if (window_closed)
                    begin
                        pend_id_reg    <= beat_reg.sensor_id;
                        pend_time_reg  <= beat_reg.sample_time;
                        pend_min_reg   <= wr_entry.window_min;
                        pend_max_reg   <= wr_entry.window_max;
                        pend_count_reg <= new_count;
                        pend_neg_reg   <= wr_entry.window_sum[SUM_W-1];
                        state_reg      <= S_DIVIDE;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIVIDE:
                begin
                    if (stats_load)
                    begin
                        stats_reg.out_sensor_id <= pend_id_reg;
                        stats_reg.min_value     <= pend_min_reg;
                        stats_reg.max_value     <= pend_max_reg;
                        stats_reg.mean_value    <= mean_fixed[SAMPLE_W-1:0];
                        stats_reg.reading_count <= pend_count_reg;
                        stats_reg.last_time     <= pend_time_reg;
                        stats_valid_reg         <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stats_valid = stats_valid_reg;
    assign stats       = stats_reg;

endmodule

### bench/testbench.sv
// self-checking testbench for the per-sensor windowed min, max and mean block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pss_pkg::*;

    localparam int SENSORS     = 16;
    // covers a window-closing reading still in the divider, with headroom
    localparam int SETTLE_PAD  = 40;
    localparam int LONG_HOLD   = 300;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               reading_valid = 1'b0;
    logic               reading_ready;
    pss_reading_t       reading       = '0;
    logic               stats_valid;
    logic               stats_ready   = 1'b0;
    pss_stats_t         stats;
    logic               cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data   = '0;

    // stimulus knobs, shared with the receiver process
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int hold_request    = 0;

    // mirror of the block: window register and per-sensor accumulators
    logic [COUNT_W-1:0] window_reg = COUNT_W'(WINDOW_RESET);
    logic [COUNT_W-1:0] fill_level [SENSORS] = '{default: '0};
    longint             win_sum    [SENSORS];
    longint             win_lo     [SENSORS];
    longint             win_hi     [SENSORS];
    pss_stats_t         pending_stats [$];

    int failures        = 0;
    int readings_taken  = 0;
    int results_seen    = 0;
    int windows_written = 0;

    per_sensor_window_stats_top #(
        .NUM_SENSORS (SENSORS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .reading_valid (reading_valid),
        .reading_ready (reading_ready),
        .reading       (reading),
        .stats_valid   (stats_valid),
        .stats_ready   (stats_ready),
        .stats         (stats),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            failures++;
        end
    endfunction

    // both channels sampled on the edge itself, before any driver update lands
    always @(posedge clk)
    begin : stats_monitor
        pss_stats_t         want;
        int unsigned        sid;
        int unsigned        span;
        logic [COUNT_W-1:0] n;
        longint             s;
        if (rst_n)
        begin
            // an accepted reading beat updates the mirror and may close a window
            if (reading_valid && reading_ready)
            begin
                readings_taken++;
                sid = reading.sensor_id;
                s   = longint'($signed(reading.sample_value));
                // ids at or above the sensor count are dropped by the block
                if (sid < SENSORS)
                begin
                    if (fill_level[sid] == '0)
                    begin
                        // first reading of a window loads all three accumulators
                        win_sum[sid] = s;
                        win_lo[sid]  = s;
                        win_hi[sid]  = s;
                    end
                    else
                    begin
                        win_sum[sid] += s;
                        if (s < win_lo[sid])
                            win_lo[sid] = s;
                        if (s > win_hi[sid])
                            win_hi[sid] = s;
                    end
                    fill_level[sid]++;
                    n = fill_level[sid];
                    // zero counts as one, anything past the maximum saturates
                    if (window_reg == '0)
                        span = 1;
                    else if (window_reg > MAX_WINDOW)
                        span = MAX_WINDOW;
                    else
                        span = window_reg;
                    // at or above the window, so a lowered window closes at once
                    if (n != '0 && n >= span)
                    begin
                        want.out_sensor_id = ID_W'(sid);
                        want.min_value     = SAMPLE_W'(win_lo[sid]);
                        want.max_value     = SAMPLE_W'(win_hi[sid]);
                        // signed division truncates toward zero
                        want.mean_value    = SAMPLE_W'(win_sum[sid] / longint'(n));
                        want.reading_count = n;
                        want.last_time     = reading.sample_time;
                        pending_stats.insert(pending_stats.size(), want);
                        fill_level[sid] = '0;
                    end
                end
            end
            // an accepted stats beat is checked against the oldest expectation
            if (stats_valid && stats_ready)
            begin
                results_seen++;
                if (pending_stats.size() == 0)
                begin
                    $display("%0t: stats beat with nothing expected, expected none, actual %p",
                             $time, stats);
                    failures++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    compare_field("out_sensor_id", want.out_sensor_id, stats.out_sensor_id);
                    compare_field("min_value", want.min_value, stats.min_value);
                    compare_field("max_value", want.max_value, stats.max_value);
                    compare_field("mean_value", want.mean_value, stats.mean_value);
                    compare_field("reading_count", want.reading_count, stats.reading_count);
                    compare_field("last_time", want.last_time, stats.last_time);
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stats_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                stats_ready <= 1'b1;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                stats_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                stats_ready <= 1'b1;
            end
            else
                stats_ready <= 1'b1;
        end
    end

    // offers one reading beat and returns on the edge that takes it;
    // valid is left high so a following beat goes out back to back
    task automatic send_reading(input logic [ID_W-1:0] id,
                                input logic signed [SAMPLE_W-1:0] value,
                                input logic [TIME_W-1:0] stamp);
        pss_reading_t beat;
        beat.sensor_id    = id;
        beat.sample_value = value;
        beat.sample_time  = stamp;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            reading_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        reading_valid <= 1'b1;
        reading       <= beat;
        do
            @(posedge clk);
        while (!(reading_valid && reading_ready));
    endtask

    // stop offering, cover a closing reading still in the divider,
    // then let every expected beat drain
    task automatic settle();
        reading_valid <= 1'b0;
        repeat (SETTLE_PAD) @(posedge clk);
        while (pending_stats.size() != 0 || stats_valid)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [COUNT_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_reg = value;
        windows_written++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // reset window of eight, sample and timestamp extremes; mean rounds toward zero
    task automatic test_default_window();
        send_reading(4'd15, 16'sh7fff, 32'h0000_0000);
        send_reading(4'd15, 16'sh8000, 32'hffff_ffff);
        send_reading(4'd15, -16'sd1,   32'h5555_5555);
        send_reading(4'd15, 16'sd0,    32'haaaa_aaaa);
        send_reading(4'd15, 16'sd1,    32'h0000_0001);
        send_reading(4'd15, -16'sd2,   32'h8000_0000);
        send_reading(4'd15, 16'sh7ffe, 32'h7fff_ffff);
        send_reading(4'd15, -16'sd32767, 32'hffff_ffff);
    endtask

    // window zero acts as one; small windows with negative fractional means
    task automatic test_small_windows();
        set_window(11'd0);
        send_reading(4'd0,  16'sh8000, 32'hffff_ffff);
        send_reading(4'd15, 16'sh7fff, 32'h0000_0000);
        send_reading(4'd7,  -16'sd1,   32'h1234_5678);
        set_window(11'd3);
        send_reading(4'd2, -16'sd1, 32'd10);
        send_reading(4'd2, -16'sd1, 32'd11);
        send_reading(4'd2, 16'sd1,  32'd12);
        set_window(11'd2);
        send_reading(4'd4, -16'sd3, 32'd20);
        send_reading(4'd4, 16'sd0,  32'd21);
    endtask

    // a window lowered below a sensor's fill closes on its next reading
    task automatic test_window_lowered();
        int k;
        set_window(11'd6);
        for (k = 0; k < 4; k++)
            send_reading(4'd9, SAMPLE_W'(k * 1000 - 1500), 32'd100 + k);
        send_reading(4'd10, 16'sd5, 32'd200);
        send_reading(4'd10, -16'sd9, 32'd201);
        set_window(11'd3);
        send_reading(4'd9, 16'sd77, 32'd300);
        send_reading(4'd10, -16'sd4, 32'd301);
    endtask

    // full 1024-reading windows at both sum extremes, above-range writes saturate
    task automatic test_window_extremes();
        int k;
        set_window(11'd1025);
        for (k = 0; k < MAX_WINDOW; k++)
            send_reading(4'd0, 16'sh8000, $urandom);
        set_window(11'd2047);
        for (k = 0; k < MAX_WINDOW - 1; k++)
            send_reading(4'd1, 16'sh7fff, $urandom);
        // drop to one: the very next reading closes a 1024-reading window
        set_window(11'd1);
        send_reading(4'd1, 16'sh7fff, 32'hffff_ffff);
    endtask

    // every reading makes a beat while the receiver holds off, so the block
    // fills its output side and must stall the reading channel
    task automatic test_output_backpressure();
        int k;
        set_window(11'd1);
        sender_gaps  = 1'b0;
        hold_request = LONG_HOLD;
        for (k = 0; k < 40; k++)
            send_reading(ID_W'($urandom_range(0, SENSORS - 1)), pick_sample(), pick_time());
        sender_gaps = 1'b1;
        settle();
    endtask

    // phases of random readings, each under its own window size; partial
    // windows carry over, so some phases start with a lowered window
    task automatic test_random_mix();
        logic [COUNT_W-1:0] phase_window [10] = '{11'd3, 11'd1, 11'd16, 11'd5, 11'd2,
                                                   11'd0, 11'd8, 11'd4, 11'd12, 11'd2};
        int phase;
        int k;
        int hot_a;
        int hot_b;
        logic [ID_W-1:0] id;
        for (phase = 0; phase < 10; phase++)
        begin
            set_window(phase_window[phase]);
            // last phase runs flat out on both sides
            if (phase == 9)
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            hot_a = $urandom_range(0, SENSORS - 1);
            hot_b = $urandom_range(0, SENSORS - 1);
            for (k = 0; k < 20; k++)
            begin
                // half the beats go to two busy sensors so wide windows still close
                case ($urandom_range(0, 3))
                    0:       id = ID_W'(hot_a);
                    1:       id = ID_W'(hot_b);
                    default: id = ID_W'($urandom_range(0, SENSORS - 1));
                endcase
                send_reading(id, pick_sample(), pick_time());
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_small_windows();
        test_window_lowered();
        test_window_extremes();
        test_output_backpressure();
        test_random_mix();
        settle();

        $display("run covered %0d readings and %0d statistics beats over %0d window writes,",
                 readings_taken, results_seen, windows_written);
        $display("including window zero, above-range sizes, lowered windows and a long stall");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
